// ----- hw/rtl/tyrc_pkg.sv -----
// ----------------------------------------------------------------------------
// Tile YUV to RGBA compositor package
// Item types for the request and result channels, register map and the
// BT.601 limited-range conversion constants.
// ----------------------------------------------------------------------------
package tyrc_pkg;

  typedef struct packed {
    logic [15:0] tile_origin_x;
    logic [15:0] tile_origin_y;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [7:0]  luma;
    logic [7:0]  chroma_blue;
    logic [7:0]  chroma_red;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] pixel_index;
    logic [31:0] pixel_word;
  } out_item_t;

  // Register map, one 32-bit word per register.
  localparam int CfgAddrWidth = 5;

  typedef enum logic [2:0] {
    REG_CROP_MODE     = 3'd0,
    REG_CROP_OFFSET_X = 3'd1,
    REG_CROP_OFFSET_Y = 3'd2,
    REG_OUTPUT_WIDTH  = 3'd3,
    REG_OUTPUT_HEIGHT = 3'd4,
    REG_OUTPUT_STRIDE = 3'd5
  } reg_idx_t;

  localparam logic [15:0] OutputSizeReset = 16'd1024;

  // Conversion arithmetic is done on 20-bit signed values.
  localparam logic signed [19:0] CoefY    = 20'sd298;
  localparam logic signed [19:0] CoefRV   = 20'sd409;
  localparam logic signed [19:0] CoefGU   = 20'sd100;
  localparam logic signed [19:0] CoefGV   = 20'sd208;
  localparam logic signed [19:0] CoefBU   = 20'sd516;
  localparam logic signed [19:0] LumaBias = 20'sd16;
  localparam logic signed [19:0] ChromaBias = 20'sd128;
  localparam logic signed [19:0] RoundBias  = 20'sd128;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;

endpackage

// ----- hw/rtl/tyrc_if.sv -----
// ----------------------------------------------------------------------------
// Tile YUV to RGBA compositor channels
// Valid/ready channels for pixel requests and placed ARGB results.
// ----------------------------------------------------------------------------
interface tyrc_in_if;
  logic               valid;
  logic               ready;
  tyrc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tyrc_out_if;
  logic                valid;
  logic                ready;
  tyrc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/tile_yuv_to_rgba_compositor.sv -----
// ----------------------------------------------------------------------------
// Tile YUV to RGBA compositor
// Places tile pixels on the output image and converts them to packed ARGB.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock and delivers one result per
// clock while the sink holds ready high. Each request passes an input
// register and then a result register, which presents the result; the path
// between them holds the destination bounds check, one 16x16 multiply-add for
// the linear index and the BT.601 conversion with channel clipping. The input
// stalls only when both registers hold requests and the sink holds ready low.
// Configuration is to be written through the APB port while no request is in
// flight; the block itself does not enforce this.
module tile_yuv_to_rgba_compositor (
  input  logic                                clk,
  input  logic                                rst_n,
  tyrc_in_if.sink                             in_ch,
  tyrc_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tyrc_pkg::CfgAddrWidth-1:0]   paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import tyrc_pkg::*;

  // Configuration registers
  logic        crop_mode_r;
  logic [15:0] crop_offset_x_r;
  logic [15:0] crop_offset_y_r;
  logic [15:0] output_width_r;
  logic [15:0] output_height_r;
  logic [15:0] output_stride_r;

  // Pipeline registers
  logic      in_valid_r,  in_valid_nxt;
  in_item_t  in_data_r,   in_data_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r,  out_data_nxt;

  logic     adv_out;
  logic     adv_in;
  logic     cfg_write;
  reg_idx_t cfg_idx;

  // Placement datapath
  logic signed [17:0] off_x;
  logic signed [17:0] off_y;
  logic signed [17:0] dst_x;
  logic signed [17:0] dst_y;
  logic               in_bounds;
  logic [31:0]        row_base;
  logic [31:0]        index_calc;

  // Conversion datapath
  logic signed [19:0] y_s;
  logic signed [19:0] u_s;
  logic signed [19:0] v_s;
  logic signed [19:0] sum_r;
  logic signed [19:0] sum_g;
  logic signed [19:0] sum_b;
  logic [7:0]         chan_r;
  logic [7:0]         chan_g;
  logic [7:0]         chan_b;

  function automatic logic [7:0] clip_channel(input logic signed [19:0] sum);
    logic signed [19:0] t;
    logic [7:0]         res;
    t = sum + RoundBias;
    if (t[19]) begin
      res = 8'd0;
    end else if (|t[18:16]) begin
      res = 8'hFF;
    end else begin
      res = t[15:8];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_t'(paddr[CfgAddrWidth-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crop_mode_r     <= 1'b0;
      crop_offset_x_r <= 16'd0;
      crop_offset_y_r <= 16'd0;
      output_width_r  <= OutputSizeReset;
      output_height_r <= OutputSizeReset;
      output_stride_r <= OutputSizeReset;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_CROP_MODE:     crop_mode_r     <= pwdata[0];
        REG_CROP_OFFSET_X: crop_offset_x_r <= pwdata[15:0];
        REG_CROP_OFFSET_Y: crop_offset_y_r <= pwdata[15:0];
        REG_OUTPUT_WIDTH:  output_width_r  <= pwdata[15:0];
        REG_OUTPUT_HEIGHT: output_height_r <= pwdata[15:0];
        REG_OUTPUT_STRIDE: output_stride_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CROP_MODE:     prdata = {31'd0, crop_mode_r};
      REG_CROP_OFFSET_X: prdata = {16'd0, crop_offset_x_r};
      REG_CROP_OFFSET_Y: prdata = {16'd0, crop_offset_y_r};
      REG_OUTPUT_WIDTH:  prdata = {16'd0, output_width_r};
      REG_OUTPUT_HEIGHT: prdata = {16'd0, output_height_r};
      REG_OUTPUT_STRIDE: prdata = {16'd0, output_stride_r};
      default:           prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign adv_out      = !out_valid_r || out_ch.ready;
  assign adv_in       = !in_valid_r || adv_out;
  assign in_ch.ready  = adv_in;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // --------------------------------------------------------------------------
  // Placement: crop, bounds check and linear index
  // --------------------------------------------------------------------------
  always_comb begin
    off_x = crop_mode_r ? $signed({2'b00, crop_offset_x_r}) : 18'sd0;
    off_y = crop_mode_r ? $signed({2'b00, crop_offset_y_r}) : 18'sd0;
    dst_x = $signed({2'b00, in_data_r.tile_origin_x}) - off_x
          + $signed({6'd0, in_data_r.pixel_col});
    dst_y = $signed({2'b00, in_data_r.tile_origin_y}) - off_y
          + $signed({6'd0, in_data_r.pixel_row});

    // Non-negative destinations fit in 17 bits.
    in_bounds = !dst_x[17] && !dst_y[17]
             && (dst_x[16:0] < {1'b0, output_width_r})
             && (dst_y[16:0] < {1'b0, output_height_r});

    row_base   = {16'd0, dst_y[15:0]} * {16'd0, output_stride_r};
    index_calc = in_bounds ? (row_base + {16'd0, dst_x[15:0]}) : 32'd0;
  end

  // --------------------------------------------------------------------------
  // BT.601 limited-range conversion
  // --------------------------------------------------------------------------
  always_comb begin
    y_s = $signed({12'd0, in_data_r.luma}) - LumaBias;
    u_s = $signed({12'd0, in_data_r.chroma_blue}) - ChromaBias;
    v_s = $signed({12'd0, in_data_r.chroma_red}) - ChromaBias;

    sum_r = CoefY * y_s + CoefRV * v_s;
    sum_g = CoefY * y_s - CoefGU * u_s - CoefGV * v_s;
    sum_b = CoefY * y_s + CoefBU * u_s;

    chan_r = clip_channel(sum_r);
    chan_g = clip_channel(sum_g);
    chan_b = clip_channel(sum_b);
  end

  // --------------------------------------------------------------------------
  // Pipeline registers
  // --------------------------------------------------------------------------
  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_data_nxt   = in_data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (adv_out) begin
      out_valid_nxt = in_valid_r;
      if (in_valid_r) begin
        out_data_nxt.write_enable = in_bounds;
        out_data_nxt.pixel_index  = index_calc;
        out_data_nxt.pixel_word   = {AlphaOpaque, chan_r, chan_g, chan_b};
      end
    end

    if (adv_in) begin
      in_valid_nxt = in_ch.valid;
      if (in_ch.valid) begin
        in_data_nxt = in_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_data_r  <= in_data_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
